### rtl/core/asbo_pkg.sv
package asbo_pkg;

    localparam int BURST_SAMPLES = 16;
    localparam int DISCARD_COUNT = 1;
    localparam int NUM_CHANNELS  = 14;
    localparam int NUM_SLOTS     = 17;

    localparam int RAW_W     = 12;
    localparam int SCALED_W  = 16;
    localparam int SLOT_W    = 5;
    localparam int CH_W      = 4;
    localparam int BCNT_W    = 7;
    localparam int ACC_W     = 22;
    localparam int BSUM_W    = 21;
    localparam int BLKCNT_W  = 9;
    localparam int SCALE_SHIFT = 4;
    localparam int BLOCK_LEN = 256;

    localparam logic [CH_W-1:0] CURRENT_CH = 4'd3;

    localparam logic [CH_W-1:0] SLOT_CHANNEL [NUM_SLOTS] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd3, 4'd7,
        4'd8, 4'd9, 4'd3, 4'd10, 4'd11, 4'd12, 4'd13, 4'd3
    };

    localparam logic SLOT_TRIGGER [NUM_SLOTS] = '{
        1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
        1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1
    };

    typedef struct packed {
        logic [SLOT_W-1:0]   slot_index;
        logic [CH_W-1:0]     channel_id;
        logic                sample_kept;
        logic [RAW_W-1:0]    adc_code;
        logic                burst_done;
        logic [15:0]         fast_value;
        logic [ACC_W-1:0]    burst_total;
        logic                loop_trigger;
        logic                round_done;
        logic [SLOT_W-1:0]   next_slot;
    } item_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot_index;
        logic [CH_W-1:0]     channel_id;
        logic                sample_kept;
        logic                slow_valid;
        logic [15:0]         slow_value;
        logic                burst_done;
        logic [15:0]         fast_value;
        logic [ACC_W-1:0]    burst_total;
        logic                loop_trigger;
        logic                round_done;
        logic [SLOT_W-1:0]   next_slot;
    } result_t;

endpackage

### rtl/core/asbo_front.sv
module asbo_front
    import asbo_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [RAW_W-1:0] adc_code,
    output logic             push,
    output item_t            push_item,
    input  logic             push_ready
);

    logic [SLOT_W-1:0] slot_ptr_reg, slot_ptr_next;
    logic [BCNT_W-1:0] bcnt_reg, bcnt_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;

    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] slot_inc;
    logic [BCNT_W-1:0] bcnt_inc;
    logic [ACC_W-1:0]  acc_add;
    logic [ACC_W:0]    fast_num;
    logic [ACC_W:0]    fast_quo;
    logic [SCALED_W-1:0] scaled;
    logic              kept;
    logic              done;

    assign in_ready = push_ready;
    assign push     = in_valid && push_ready;

    always_comb
    begin
        slot     = (slot_ptr_reg < SLOT_W'(NUM_SLOTS)) ? slot_ptr_reg : '0;
        scaled   = {adc_code, {SCALE_SHIFT{1'b0}}};
        kept     = (bcnt_reg >= BCNT_W'(DISCARD_COUNT));
        acc_add  = kept ? (acc_reg + ACC_W'(scaled)) : acc_reg;
        bcnt_inc = bcnt_reg + 1'b1;
        done     = (bcnt_inc >= BCNT_W'(BURST_SAMPLES + DISCARD_COUNT));
        fast_num = {1'b0, acc_add} + (ACC_W+1)'(BURST_SAMPLES / 2);
        fast_quo = fast_num / (ACC_W+1)'(BURST_SAMPLES);
        slot_inc = (slot == SLOT_W'(NUM_SLOTS - 1)) ? '0 : slot + 1'b1;

        push_item.slot_index   = slot;
        push_item.channel_id   = SLOT_CHANNEL[slot];
        push_item.sample_kept  = kept;
        push_item.adc_code     = adc_code;
        push_item.burst_done   = done;
        push_item.fast_value   = done ? fast_quo[15:0] : '0;
        push_item.burst_total  = done ? acc_add : '0;
        push_item.loop_trigger = done && SLOT_TRIGGER[slot];
        push_item.round_done   = done && (slot_inc == '0);
        push_item.next_slot    = done ? slot_inc : slot;

        slot_ptr_next = slot_ptr_reg;
        bcnt_next     = bcnt_reg;
        acc_next      = acc_reg;
        if (push)
        begin
            if (done)
            begin
                slot_ptr_next = slot_inc;
                bcnt_next     = '0;
                acc_next      = '0;
            end
            else
            begin
                bcnt_next = bcnt_inc;
                acc_next  = acc_add;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_ptr_reg <= '0;
            bcnt_reg     <= '0;
            acc_reg      <= '0;
        end
        else
        begin
            slot_ptr_reg <= slot_ptr_next;
            bcnt_reg     <= bcnt_next;
            acc_reg      <= acc_next;
        end
    end

endmodule

### rtl/core/asbo_fifo.sv
module asbo_fifo
    import asbo_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  item_t wr_item,
    output logic  rd_valid,
    input  logic  rd_pop,
    output item_t rd_item
);

    item_t      mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_wr;
    logic       do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/core/asbo_back.sv
module asbo_back
    import asbo_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_pop,
    input  item_t   item,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t result
);

    logic [BSUM_W-1:0]   bsum_reg [NUM_CHANNELS];
    logic [BLKCNT_W-1:0] bcnt_reg [NUM_CHANNELS];
    logic [15:0]         slow_reg [NUM_CHANNELS];
    logic                valid_reg, valid_next;
    result_t             result_reg, result_next;

    logic [BSUM_W-1:0]   sum_new;
    logic [BLKCNT_W-1:0] cnt_new;
    logic [BSUM_W:0]     sum_round;
    logic [15:0]         slow_new;
    logic [SCALED_W-1:0] scaled;
    logic                seed;
    logic                block_end;
    logic [CH_W-1:0]     ch;

    assign item_pop  = item_valid && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign result    = result_reg;

    always_comb
    begin
        ch        = item.channel_id;
        scaled    = {item.adc_code, {SCALE_SHIFT{1'b0}}};
        sum_new   = bsum_reg[ch] + BSUM_W'(item.adc_code);
        cnt_new   = bcnt_reg[ch] + 1'b1;
        sum_round = {1'b0, sum_new} + (BSUM_W+1)'(1 << (SCALE_SHIFT - 1));
        seed      = item.sample_kept && (cnt_new == BLKCNT_W'(1)) && (slow_reg[ch] == '0);
        block_end = item.sample_kept && (cnt_new >= BLKCNT_W'(BLOCK_LEN));

        slow_new = slow_reg[ch];
        if (seed)
        begin
            slow_new = scaled;
        end
        if (block_end)
        begin
            slow_new = sum_round[SCALE_SHIFT +: 16];
        end

        result_next.slot_index   = item.slot_index;
        result_next.channel_id   = ch;
        result_next.sample_kept  = item.sample_kept;
        result_next.slow_valid   = seed || block_end;
        result_next.slow_value   = slow_new;
        result_next.burst_done   = item.burst_done;
        result_next.fast_value   = item.fast_value;
        result_next.burst_total  = item.burst_total;
        result_next.loop_trigger = item.loop_trigger;
        result_next.round_done   = item.round_done;
        result_next.next_slot    = item.next_slot;

        valid_next = valid_reg;
        if (item_pop)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                bsum_reg[i] <= '0;
                bcnt_reg[i] <= '0;
                slow_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            if (item_pop && item.sample_kept)
            begin
                bsum_reg[ch] <= block_end ? '0 : sum_new;
                bcnt_reg[ch] <= block_end ? '0 : cnt_new;
                slow_reg[ch] <= slow_new;
            end
        end
    end

endmodule

### rtl/core/adc_scan_burst_oversampler_top.sv
// Path: an accepted transaction is stored in the queue, then registered at the output.
// Throughput: one transaction per cycle while the queue is not full; a two-entry queue
// separates burst sequencing from the per-channel read-modify-write of the block sums.
// Reset: rst_n asynchronous, active low; clears scan position, burst state,
// all per-channel block sums, counts and slow results, and both queue and output valid.
module adc_scan_burst_oversampler_top
    import asbo_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [RAW_W-1:0]  adc_code,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SLOT_W-1:0] slot_index,
    output logic [CH_W-1:0]   channel_id,
    output logic              sample_kept,
    output logic              slow_valid,
    output logic [15:0]       slow_value,
    output logic              burst_done,
    output logic [15:0]       fast_value,
    output logic [ACC_W-1:0]  burst_total,
    output logic              loop_trigger,
    output logic              round_done,
    output logic [SLOT_W-1:0] next_slot
);

    logic    push;
    logic    push_ready;
    item_t   push_item;
    logic    q_valid;
    logic    q_pop;
    item_t   q_item;
    result_t result;

    asbo_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .adc_code   (adc_code),
        .push       (push),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    asbo_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push),
        .wr_ready (push_ready),
        .wr_item  (push_item),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_item  (q_item)
    );

    asbo_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item_pop   (q_pop),
        .item       (q_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result)
    );

    assign slot_index   = result.slot_index;
    assign channel_id   = result.channel_id;
    assign sample_kept  = result.sample_kept;
    assign slow_valid   = result.slow_valid;
    assign slow_value   = result.slow_value;
    assign burst_done   = result.burst_done;
    assign fast_value   = result.fast_value;
    assign burst_total  = result.burst_total;
    assign loop_trigger = result.loop_trigger;
    assign round_done   = result.round_done;
    assign next_slot    = result.next_slot;

`ifndef SYNTH
    a_round_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && round_done |-> burst_done && next_slot == '0)
        else $error("round_done without completed burst to slot zero");

    a_slot_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !burst_done |-> next_slot == slot_index)
        else $error("slot advanced mid-burst");

    a_trigger_current: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && loop_trigger |-> burst_done && channel_id == CURRENT_CH)
        else $error("loop_trigger outside current-sense burst end");

    a_slow_needs_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && slow_valid |-> sample_kept)
        else $error("slow_valid on discarded sample");
`endif

endmodule
